### src/fpsa_pkg.sv
// fpsa_pkg: shared widths, opcode and format codes, and the internal control
// record of the fixed-point saturating alu pipeline
// depends on nothing; used by the channel interfaces and the top level

package fpsa_pkg;

   // payload widths
   localparam int OPCODE_W = 4;
   localparam int FORMAT_W = 2;
   localparam int DATA_W   = 32;
   localparam int PROD_W   = 2 * DATA_W;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_ADD     = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_SAT_ADD = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_SUB     = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_SAT_SUB = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_MUL     = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_SAT_MUL = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_FLOOR   = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_FRACT   = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_WIDEN   = 4'd8;
   localparam logic [OPCODE_W-1:0] OP_NARROW  = 4'd9;

   // q formats
   localparam logic [FORMAT_W-1:0] FMT_Q8_8   = 2'd0;
   localparam logic [FORMAT_W-1:0] FMT_Q16_16 = 2'd1;
   localparam logic [FORMAT_W-1:0] FMT_Q8_24  = 2'd2;
   localparam logic [FORMAT_W-1:0] FMT_Q24_8  = 2'd3;

   // fraction masks
   localparam logic [DATA_W-1:0] FRAC_MASK_8  = 32'h0000_00FF;
   localparam logic [DATA_W-1:0] FRAC_MASK_16 = 32'h0000_FFFF;
   localparam logic [DATA_W-1:0] FRAC_MASK_24 = 32'h00FF_FFFF;

   // saturation limits, as 32-bit patterns
   localparam logic [DATA_W-1:0] MAX_32 = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MIN_32 = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MAX_16 = 32'h0000_7FFF;
   localparam logic [DATA_W-1:0] MIN_16 = 32'hFFFF_8000;

   // internal operation classes
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_ZERO   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SUB    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MUL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FLOOR  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_FRACT  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_WIDEN  = 3'd6;
   localparam logic [KIND_W-1:0] KIND_NARROW = 3'd7;

   // control record that travels down the pipeline with each item
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic                sat;     // clamp instead of wrap
      logic                unsup;   // opcode not defined in q24.8
      logic                wide;    // 32-bit word, else 16-bit
      logic [FORMAT_W-1:0] fmt;
   } ctrl_type;

endpackage

### src/fpsa_req_if.sv
// fpsa_req_if: request channel of the fixed-point alu (valid/ready + operands)
// depends on fpsa_pkg for the payload widths

interface fpsa_req_if;
   logic                                valid;
   logic                                ready;
   logic [fpsa_pkg::OPCODE_W-1:0]       opcode;
   logic [fpsa_pkg::FORMAT_W-1:0]       format;
   logic signed [fpsa_pkg::DATA_W-1:0]  operand_a;
   logic signed [fpsa_pkg::DATA_W-1:0]  operand_b;

   modport source (output valid, opcode, format, operand_a, operand_b, input ready);
   modport sink   (input valid, opcode, format, operand_a, operand_b, output ready);
endinterface

### src/fpsa_rsp_if.sv
// fpsa_rsp_if: response channel of the fixed-point alu (valid/ready + result)
// depends on fpsa_pkg for the payload widths

interface fpsa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [fpsa_pkg::DATA_W-1:0]  result_value;
   logic                                unsupported;

   modport source (output valid, result_value, unsupported, input ready);
   modport sink   (input valid, result_value, unsupported, output ready);
endinterface

### src/fixed_point_saturating_alu.sv
// fixed_point_saturating_alu: four-stage pipelined q-format alu
// depends on fpsa_pkg, fpsa_req_if and fpsa_rsp_if
//
// Usage
//   req: one transfer per operation (opcode, format, operand_a, operand_b).
//   rsp: one transfer per operation (result_value, unsupported), in order.
//   The four register stages are decode and operand sign extension,
//   add/sub/multiply, product scaling, then clamp or wrap; rsp.valid is
//   the valid bit of the last one.
//   Throughput is one operation per cycle while rsp.ready stays high; the 32x32
//   multiplier sits wholly in stage two and every stage takes a new item each cycle.
//   Each stage carries its own valid bit and loads whenever it is empty or
//   the stage after it moves on, so bubbles are squeezed out during a stall.
//   When rsp.ready is low the result holds in the last stage and the stages
//   behind it keep filling; req.ready drops only when all four are full.
//   Synchronous reset empties the pipeline; no payload is cleared and no
//   result is produced for items in flight at reset.
//   There is no configuration and no kept state between operations.

module fixed_point_saturating_alu (
   input  logic              clock,
   input  logic              reset,
   fpsa_req_if.sink          req,
   fpsa_rsp_if.source        rsp
);

   localparam int DW = fpsa_pkg::DATA_W;
   localparam int PW = fpsa_pkg::PROD_W;

   // stage enables (ready chain)
   logic en_s1, en_s2, en_s3, en_s4;

   // stage 1: decode and sign extension
   logic                       vld_s1_ff, vld_s1_in;
   fpsa_pkg::ctrl_type         ctrl_s1_ff, ctrl_s1_in;
   logic signed [DW-1:0]       a_s1_ff, a_s1_in;
   logic signed [DW-1:0]       b_s1_ff, b_s1_in;

   // stage 2: arithmetic
   logic                       vld_s2_ff;
   fpsa_pkg::ctrl_type         ctrl_s2_ff;
   logic signed [PW-1:0]       val_s2_ff, val_s2_in;

   // stage 3: product scaling
   logic                       vld_s3_ff;
   fpsa_pkg::ctrl_type         ctrl_s3_ff;
   logic signed [PW-1:0]       val_s3_ff, val_s3_in;

   // stage 4: output register
   logic                       vld_s4_ff;
   fpsa_pkg::ctrl_type         ctrl_s4_ff;
   logic [DW-1:0]              res_s4_ff, res_s4_in;

   logic signed [DW:0]         sum;
   logic signed [PW-1:0]       prod;
   logic [DW-1:0]              frac_mask;
   logic                       pos_ovf, neg_ovf;

   // ready chain from the output back to the request side
   always_comb begin
      en_s4 = !vld_s4_ff || rsp.ready;
      en_s3 = !vld_s3_ff || en_s4;
      en_s2 = !vld_s2_ff || en_s3;
      en_s1 = !vld_s1_ff || en_s2;
   end

   assign req.ready = en_s1;
   assign vld_s1_in = req.valid;

   // decode opcode and format into the control record
   always_comb begin
      ctrl_s1_in.fmt   = req.format;
      ctrl_s1_in.sat   = 1'b0;
      ctrl_s1_in.unsup = 1'b0;
      ctrl_s1_in.wide  = (req.format != fpsa_pkg::FMT_Q8_8);
      ctrl_s1_in.kind  = fpsa_pkg::KIND_ZERO;
      case (req.opcode)
         fpsa_pkg::OP_ADD: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_ADD;
         end
         fpsa_pkg::OP_SAT_ADD: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_ADD;
            ctrl_s1_in.sat  = 1'b1;
         end
         fpsa_pkg::OP_SUB: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_SUB;
         end
         fpsa_pkg::OP_SAT_SUB: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_SUB;
            ctrl_s1_in.sat  = 1'b1;
         end
         fpsa_pkg::OP_MUL: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_MUL;
         end
         fpsa_pkg::OP_SAT_MUL: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_MUL;
            ctrl_s1_in.sat  = 1'b1;
         end
         fpsa_pkg::OP_FLOOR: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_FLOOR;
         end
         fpsa_pkg::OP_FRACT: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_FRACT;
         end
         fpsa_pkg::OP_WIDEN: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_WIDEN;
            ctrl_s1_in.wide = 1'b1;
         end
         fpsa_pkg::OP_NARROW: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_NARROW;
            ctrl_s1_in.wide = 1'b1;
         end
         default: begin
            ctrl_s1_in.kind = fpsa_pkg::KIND_ZERO;
         end
      endcase
      // q24.8 flags sub, mul, floor and fract, plain and saturating, as unsupported
      if (req.format == fpsa_pkg::FMT_Q24_8 &&
          (req.opcode == fpsa_pkg::OP_SUB   || req.opcode == fpsa_pkg::OP_SAT_SUB ||
           req.opcode == fpsa_pkg::OP_MUL   || req.opcode == fpsa_pkg::OP_SAT_MUL ||
           req.opcode == fpsa_pkg::OP_FLOOR || req.opcode == fpsa_pkg::OP_FRACT)) begin
         ctrl_s1_in.kind  = fpsa_pkg::KIND_ZERO;
         ctrl_s1_in.sat   = 1'b0;
         ctrl_s1_in.unsup = 1'b1;
      end
   end

   // q8.8 operands use only their low 16 bits, except for widen and narrow
   always_comb begin
      if (ctrl_s1_in.wide) begin
         a_s1_in = req.operand_a;
         b_s1_in = req.operand_b;
      end else begin
         a_s1_in = {{(DW/2){req.operand_a[DW/2-1]}}, req.operand_a[DW/2-1:0]};
         b_s1_in = {{(DW/2){req.operand_b[DW/2-1]}}, req.operand_b[DW/2-1:0]};
      end
   end

   // stage 2: add, subtract, multiply and the unary operations
   always_comb begin
      case (ctrl_s1_ff.fmt)
         fpsa_pkg::FMT_Q16_16: frac_mask = fpsa_pkg::FRAC_MASK_16;
         fpsa_pkg::FMT_Q8_24:  frac_mask = fpsa_pkg::FRAC_MASK_24;
         default:              frac_mask = fpsa_pkg::FRAC_MASK_8;
      endcase

      if (ctrl_s1_ff.kind == fpsa_pkg::KIND_SUB) begin
         sum = (DW+1)'(a_s1_ff) - (DW+1)'(b_s1_ff);
      end else begin
         sum = (DW+1)'(a_s1_ff) + (DW+1)'(b_s1_ff);
      end
      prod = PW'(a_s1_ff) * PW'(b_s1_ff);

      case (ctrl_s1_ff.kind)
         fpsa_pkg::KIND_ADD,
         fpsa_pkg::KIND_SUB: begin
            val_s2_in = {{(PW-DW-1){sum[DW]}}, sum};
         end
         fpsa_pkg::KIND_MUL: begin
            val_s2_in = prod;
         end
         fpsa_pkg::KIND_FLOOR: begin
            val_s2_in = {{(PW-DW){1'b0}}, a_s1_ff & ~frac_mask};
         end
         fpsa_pkg::KIND_FRACT: begin
            val_s2_in = {{(PW-DW){1'b0}}, a_s1_ff & frac_mask};
         end
         fpsa_pkg::KIND_WIDEN: begin
            val_s2_in = {{(PW-DW){1'b0}}, {(DW/4){a_s1_ff[DW/2-1]}},
                         a_s1_ff[DW/2-1:0], {(DW/4){1'b0}}};
         end
         fpsa_pkg::KIND_NARROW: begin
            val_s2_in = {{(PW-DW){1'b0}}, {(DW/2){a_s1_ff[DW-DW/4-1]}},
                         a_s1_ff[DW-DW/4-1:DW/4]};
         end
         default: begin
            val_s2_in = '0;
         end
      endcase
   end

   // stage 3: floor-scale the product by the fraction width
   always_comb begin
      val_s3_in = val_s2_ff;
      if (ctrl_s2_ff.kind == fpsa_pkg::KIND_MUL) begin
         case (ctrl_s2_ff.fmt)
            fpsa_pkg::FMT_Q16_16: val_s3_in = val_s2_ff >>> 16;
            fpsa_pkg::FMT_Q8_24:  val_s3_in = val_s2_ff >>> 24;
            default:              val_s3_in = val_s2_ff >>> 8;
         endcase
      end
   end

   // stage 4: zero for unsupported or undefined ops, else clamp or wrap to the word width, sign-extend to 32 bits
   always_comb begin
      if (ctrl_s3_ff.wide) begin
         pos_ovf = !val_s3_ff[PW-1] && (|val_s3_ff[PW-2:DW-1]);
         neg_ovf =  val_s3_ff[PW-1] && !(&val_s3_ff[PW-2:DW-1]);
      end else begin
         pos_ovf = !val_s3_ff[PW-1] && (|val_s3_ff[PW-2:DW/2-1]);
         neg_ovf =  val_s3_ff[PW-1] && !(&val_s3_ff[PW-2:DW/2-1]);
      end

      if (ctrl_s3_ff.kind == fpsa_pkg::KIND_ZERO) begin
         res_s4_in = '0;
      end else if (ctrl_s3_ff.sat && pos_ovf) begin
         res_s4_in = ctrl_s3_ff.wide ? fpsa_pkg::MAX_32 : fpsa_pkg::MAX_16;
      end else if (ctrl_s3_ff.sat && neg_ovf) begin
         res_s4_in = ctrl_s3_ff.wide ? fpsa_pkg::MIN_32 : fpsa_pkg::MIN_16;
      end else if (ctrl_s3_ff.wide) begin
         res_s4_in = val_s3_ff[DW-1:0];
      end else begin
         res_s4_in = {{(DW/2){val_s3_ff[DW/2-1]}}, val_s3_ff[DW/2-1:0]};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_s1_ff <= 1'b0;
         vld_s2_ff <= 1'b0;
         vld_s3_ff <= 1'b0;
         vld_s4_ff <= 1'b0;
      end else begin
         if (en_s1) vld_s1_ff <= vld_s1_in;
         if (en_s2) vld_s2_ff <= vld_s1_ff;
         if (en_s3) vld_s3_ff <= vld_s2_ff;
         if (en_s4) vld_s4_ff <= vld_s3_ff;
      end
   end

   // payload and control registers
   always_ff @(posedge clock) begin
      if (en_s1) begin
         ctrl_s1_ff <= ctrl_s1_in;
         a_s1_ff    <= a_s1_in;
         b_s1_ff    <= b_s1_in;
      end
      if (en_s2) begin
         ctrl_s2_ff <= ctrl_s1_ff;
         val_s2_ff  <= val_s2_in;
      end
      if (en_s3) begin
         ctrl_s3_ff <= ctrl_s2_ff;
         val_s3_ff  <= val_s3_in;
      end
      if (en_s4) begin
         ctrl_s4_ff <= ctrl_s3_ff;
         res_s4_ff  <= res_s4_in;
      end
   end

   // response channel
   assign rsp.valid        = vld_s4_ff;
   assign rsp.result_value = res_s4_ff;
   assign rsp.unsupported  = ctrl_s4_ff.unsup;

   // the request side is held off only when every stage is full and stalled
   assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (vld_s1_ff && vld_s2_ff && vld_s3_ff && vld_s4_ff && !rsp.ready))
      else $error("request stalled with an empty pipeline stage");

   // an unsupported operation returns zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.unsupported) |-> (rsp.result_value == '0))
      else $error("unsupported operation gave a non-zero result");

   // only q24.8 items can carry the unsupported flag
   assert property (@(posedge clock) disable iff (reset)
      (vld_s4_ff && ctrl_s4_ff.unsup) |-> (ctrl_s4_ff.fmt == fpsa_pkg::FMT_Q24_8))
      else $error("unsupported flag on a format other than q24.8");

   // 16-bit results leave sign-extended
   assert property (@(posedge clock) disable iff (reset)
      (vld_s4_ff && !ctrl_s4_ff.wide) |->
         (res_s4_ff[DW-1:DW/2] == {(DW/2){res_s4_ff[DW/2-1]}}))
      else $error("q8.8 result not sign-extended");

endmodule

### bench/fixed_point_saturating_alu_tb.sv
// fixed_point_saturating_alu_tb: self-checking bench for the q-format alu, with
// a scoreboard class that predicts each result and random stall/idle traffic
// depends on fpsa_pkg, fpsa_req_if, fpsa_rsp_if and fixed_point_saturating_alu
`timescale 1ns / 1ps

module fixed_point_saturating_alu_tb;

   // opcodes above narrow have no operation behind them
   localparam logic [fpsa_pkg::OPCODE_W-1:0] OP_UNDEF_LO = 4'd10;
   localparam logic [fpsa_pkg::OPCODE_W-1:0] OP_UNDEF_HI = 4'd15;

   localparam int IDLE_PERCENT   = 37;
   localparam int HOLD_CYCLES    = 60;
   localparam int STALL_LIMIT    = 2000;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int DRAIN_CYCLES   = 10;

   typedef struct packed {
      logic [fpsa_pkg::DATA_W-1:0] value;
      logic                        unsup;
   } alu_outcome_type;

   // scoreboard: predicts the alu result of each accepted operation
   class alu_result_ledger;
      alu_outcome_type expected_results[$];
      int              failures;

      function new();
         failures = 0;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // low w bits (16 or 32) of a word as a signed number
      function longint word_to_int(logic [fpsa_pkg::DATA_W-1:0] v, int w);
         if (w == 16)
            return {{48{v[15]}}, v[15:0]};
         return {{32{v[31]}}, v};
      endfunction

      // keep the low w bits and sign-extend them to 32
      function logic [fpsa_pkg::DATA_W-1:0] wrap_word(longint r, int w);
         if (w == 16)
            return {{16{r[15]}}, r[15:0]};
         return r[31:0];
      endfunction

      function logic [fpsa_pkg::DATA_W-1:0] clamp_word(longint r, int w);
         longint hi;
         longint lo;
         hi = (w == 16) ? 64'sd32767 : 64'sd2147483647;
         lo = -hi - 1;
         if (r > hi) r = hi;
         if (r < lo) r = lo;
         return wrap_word(r, w);
      endfunction

      function alu_outcome_type compute_alu_result(logic [fpsa_pkg::OPCODE_W-1:0] op,
                                                   logic [fpsa_pkg::FORMAT_W-1:0] fmt,
                                                   logic [fpsa_pkg::DATA_W-1:0] a_raw,
                                                   logic [fpsa_pkg::DATA_W-1:0] b_raw);
         alu_outcome_type o;
         int              word_bits;
         int              frac_bits;
         longint          a;
         longint          b;
         longint          frac_mask;
         word_bits = (fmt == fpsa_pkg::FMT_Q8_8) ? 16 : 32;
         frac_bits = (fmt == fpsa_pkg::FMT_Q8_24) ? 24 :
                     (fmt == fpsa_pkg::FMT_Q16_16) ? 16 : 8;
         frac_mask = (64'sd1 <<< frac_bits) - 1;
         a = word_to_int(a_raw, word_bits);
         b = word_to_int(b_raw, word_bits);
         o.value = '0;
         o.unsup = 1'b0;
         if (op == fpsa_pkg::OP_WIDEN) begin
            o.value = wrap_word(word_to_int(a_raw, 16) <<< 8, 32);
         end else if (op == fpsa_pkg::OP_NARROW) begin
            o.value = wrap_word(word_to_int(a_raw, 32) >>> 8, 16);
         end else if (op > fpsa_pkg::OP_NARROW) begin
            o.value = '0;
         end else if (fmt == fpsa_pkg::FMT_Q24_8 && op > fpsa_pkg::OP_SAT_ADD) begin
            o.unsup = 1'b1;
         end else begin
            case (op)
               fpsa_pkg::OP_ADD:     o.value = wrap_word(a + b, word_bits);
               fpsa_pkg::OP_SAT_ADD: o.value = clamp_word(a + b, word_bits);
               fpsa_pkg::OP_SUB:     o.value = wrap_word(a - b, word_bits);
               fpsa_pkg::OP_SAT_SUB: o.value = clamp_word(a - b, word_bits);
               // arithmetic shift of the full product floors toward minus infinity
               fpsa_pkg::OP_MUL:     o.value = wrap_word((a * b) >>> frac_bits, word_bits);
               fpsa_pkg::OP_SAT_MUL: o.value = clamp_word((a * b) >>> frac_bits, word_bits);
               fpsa_pkg::OP_FLOOR:   o.value = wrap_word(a & ~frac_mask, word_bits);
               default:              o.value = wrap_word(a & frac_mask, word_bits);
            endcase
         end
         return o;
      endfunction

      function void note_request(logic [fpsa_pkg::OPCODE_W-1:0] op,
                                 logic [fpsa_pkg::FORMAT_W-1:0] fmt,
                                 logic [fpsa_pkg::DATA_W-1:0] a_raw,
                                 logic [fpsa_pkg::DATA_W-1:0] b_raw);
         expected_results.push_back(compute_alu_result(op, fmt, a_raw, b_raw));
      endfunction

      function void check_response(logic [fpsa_pkg::DATA_W-1:0] value, logic unsup);
         alu_outcome_type exp_item;
         if (expected_results.size() == 0) begin
            $display("%0t: result with nothing outstanding: value %h unsupported %b",
                     $time, value, unsup);
            failures++;
            return;
         end
         exp_item = expected_results.pop_front();
         if (value !== exp_item.value) begin
            $display("%0t: result_value mismatch: expected %h actual %h",
                     $time, exp_item.value, value);
            failures++;
         end
         if (unsup !== exp_item.unsup) begin
            $display("%0t: unsupported mismatch: expected %b actual %b",
                     $time, exp_item.unsup, unsup);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   fpsa_req_if req_bus ();
   fpsa_rsp_if rsp_bus ();

   fixed_point_saturating_alu uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   alu_result_ledger ledger = new();

   // traffic shaping flags for the sender and receiver processes, and the watchdog count
   bit req_idle_on  = 1'b1;
   bit rsp_steady   = 1'b0;
   bit rsp_hold_req = 1'b0;
   int stall_cycles = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // operand mix: full-width noise, corners, and sign-extended fields of random width
   function automatic logic [fpsa_pkg::DATA_W-1:0] pick_operand();
      logic [fpsa_pkg::DATA_W-1:0] r;
      logic [fpsa_pkg::DATA_W-1:0] mask;
      int                          k;
      r = $urandom;
      case ($urandom_range(9))
         0, 1: return r;
         2: begin
            case ($urandom_range(10))
               0: return 32'h0000_0000;
               1: return 32'h0000_0001;
               2: return 32'hFFFF_FFFF;
               3: return 32'h0000_7FFF;
               4: return 32'hFFFF_8000;
               5: return 32'h7FFF_FFFF;
               6: return 32'h8000_0000;
               7: return 32'h0000_0100;
               8: return 32'h0001_0000;
               9: return 32'h0100_0000;
               default: return 32'h0000_FFFF;
            endcase
         end
         default: begin
            k    = $urandom_range(2, 31);
            mask = (32'h1 << k) - 1;
            return r[k-1] ? (r | ~mask) : (r & mask);
         end
      endcase
   endfunction

   // one request transfer, with optional random idle cycles ahead of it
   task automatic push_op(input logic [fpsa_pkg::OPCODE_W-1:0] op,
                          input logic [fpsa_pkg::FORMAT_W-1:0] fmt,
                          input logic [fpsa_pkg::DATA_W-1:0] a_raw,
                          input logic [fpsa_pkg::DATA_W-1:0] b_raw);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.format    <= fmt;
      req_bus.operand_a <= a_raw;
      req_bus.operand_b <= b_raw;
      do @(posedge clock); while (!req_bus.ready);
      ledger.note_request(op, fmt, a_raw, b_raw);
   endtask

   task automatic push_random_op();
      logic [fpsa_pkg::OPCODE_W-1:0] op;
      logic [fpsa_pkg::FORMAT_W-1:0] fmt;
      int unsigned                   pick;
      if ($urandom_range(99) < 90)
         pick = $urandom_range(fpsa_pkg::OP_ADD, fpsa_pkg::OP_NARROW);
      else
         pick = $urandom_range(OP_UNDEF_LO, OP_UNDEF_HI);
      op   = pick[fpsa_pkg::OPCODE_W-1:0];
      pick = $urandom_range(fpsa_pkg::FMT_Q8_8, fpsa_pkg::FMT_Q24_8);
      fmt  = pick[fpsa_pkg::FORMAT_W-1:0];
      push_op(op, fmt, pick_operand(), pick_operand());
   endtask

   task automatic wait_for_drain();
      while (ledger.pending() != 0)
         @(posedge clock);
   endtask

   // result receiver: random stalls, steady stretches and one long hold-off
   initial begin
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= rsp_steady || ($urandom_range(99) >= IDLE_PERCENT);
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready)
            ledger.check_response(rsp_bus.result_value, rsp_bus.unsupported);
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("fixed_point_saturating_alu_tb: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // stimulus
   initial begin
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= fpsa_pkg::OP_ADD;
      req_bus.format    <= fpsa_pkg::FMT_Q8_8;
      req_bus.operand_a <= '0;
      req_bus.operand_b <= '0;
      reset             <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: clamp both ends of each word, wrap at 16-bit max and 32-bit min
      push_op(fpsa_pkg::OP_ADD,     fpsa_pkg::FMT_Q8_8,   32'h0000_7FFF, 32'h0000_0001);
      push_op(fpsa_pkg::OP_SAT_ADD, fpsa_pkg::FMT_Q8_8,   32'h0000_7FFF, 32'h0000_0001);
      push_op(fpsa_pkg::OP_SAT_ADD, fpsa_pkg::FMT_Q8_8,   32'hFFFF_8000, 32'h5A5A_8000);
      push_op(fpsa_pkg::OP_SUB,     fpsa_pkg::FMT_Q16_16, 32'h8000_0000, 32'h0000_0001);
      push_op(fpsa_pkg::OP_SAT_SUB, fpsa_pkg::FMT_Q16_16, 32'h8000_0000, 32'h0000_0001);
      push_op(fpsa_pkg::OP_SAT_SUB, fpsa_pkg::FMT_Q8_24,  32'h7FFF_FFFF, 32'hFFFF_FFFF);
      // negative product that must floor, not truncate toward zero
      push_op(fpsa_pkg::OP_MUL,     fpsa_pkg::FMT_Q8_8,   32'hFFFF_FFFF, 32'h0000_0080);
      push_op(fpsa_pkg::OP_SAT_MUL, fpsa_pkg::FMT_Q8_8,   32'hFFFF_8000, 32'hFFFF_8000);
      push_op(fpsa_pkg::OP_SAT_MUL, fpsa_pkg::FMT_Q8_8,   32'h0000_7FFF, 32'hFFFF_8000);
      push_op(fpsa_pkg::OP_SAT_MUL, fpsa_pkg::FMT_Q8_8,   32'hFFFF_FF00, 32'h0000_7FFF);
      push_op(fpsa_pkg::OP_MUL,     fpsa_pkg::FMT_Q16_16, 32'h8000_0000, 32'h8000_0000);
      push_op(fpsa_pkg::OP_SAT_MUL, fpsa_pkg::FMT_Q8_24,  32'h8000_0000, 32'h7FFF_FFFF);
      // unary ops, with junk in the upper half of q8.8 operands
      push_op(fpsa_pkg::OP_FLOOR,   fpsa_pkg::FMT_Q8_8,   32'h1234_8F7F, 32'hFFFF_FFFF);
      push_op(fpsa_pkg::OP_FLOOR,   fpsa_pkg::FMT_Q16_16, 32'hFFFF_8001, 32'h0000_0000);
      push_op(fpsa_pkg::OP_FRACT,   fpsa_pkg::FMT_Q8_24,  32'h80FF_FFFF, 32'h0000_0000);
      push_op(fpsa_pkg::OP_FRACT,   fpsa_pkg::FMT_Q8_8,   32'hABCD_FF80, 32'h0000_0000);
      push_op(fpsa_pkg::OP_WIDEN,   fpsa_pkg::FMT_Q24_8,  32'h7654_8001, 32'h0000_0000);
      push_op(fpsa_pkg::OP_NARROW,  fpsa_pkg::FMT_Q24_8,  32'h8000_0000, 32'h0000_0000);
      push_op(fpsa_pkg::OP_NARROW,  fpsa_pkg::FMT_Q8_8,   32'h7FFF_FFFF, 32'h0000_0000);
      // q24.8: add works, everything from sub to fract is flagged
      push_op(fpsa_pkg::OP_ADD,     fpsa_pkg::FMT_Q24_8,  32'h7FFF_FFFF, 32'h0000_0001);
      push_op(fpsa_pkg::OP_SAT_ADD, fpsa_pkg::FMT_Q24_8,  32'h8000_0000, 32'h8000_0000);
      push_op(fpsa_pkg::OP_SUB,     fpsa_pkg::FMT_Q24_8,  32'h0000_0100, 32'h0000_0001);
      push_op(fpsa_pkg::OP_SAT_MUL, fpsa_pkg::FMT_Q24_8,  32'h0000_0100, 32'h0000_0100);
      push_op(fpsa_pkg::OP_FRACT,   fpsa_pkg::FMT_Q24_8,  32'h0000_01FF, 32'h0000_0000);
      push_op(OP_UNDEF_LO,          fpsa_pkg::FMT_Q16_16, 32'h1234_5678, 32'h1111_1111);
      push_op(OP_UNDEF_HI,          fpsa_pkg::FMT_Q24_8,  32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // sender pause until the pipeline has emptied
      req_bus.valid <= 1'b0;
      wait_for_drain();

      repeat (RANDOM_ITEMS / 3) push_random_op();

      // long receiver hold-off while requests keep coming back to back
      req_idle_on  = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (40) push_random_op();

      // stretch with no idling on either side
      rsp_steady = 1'b1;
      repeat (RANDOM_ITEMS / 5) push_random_op();
      rsp_steady  = 1'b0;
      req_idle_on = 1'b1;

      repeat (RANDOM_ITEMS - RANDOM_ITEMS / 3 - 40 - RANDOM_ITEMS / 5) push_random_op();

      req_bus.valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("fixed_point_saturating_alu_tb: PASS");
      end else begin
         $display("fixed_point_saturating_alu_tb: FAIL");
      end
      $finish;
   end

endmodule
